[rtl/fwtp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fwtp_pkg;

    localparam int QUEUE_DEPTH = 16;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_PURGE   = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_RANGE = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] msg_handle;
        logic [1:0]  msg_kind;
        logic [15:0] agent_id;
        logic [31:0] stamp;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic [15:0] out_handle;
        logic [1:0]  out_kind;
        logic [15:0] out_agent;
        logic [31:0] out_stamp;
        logic        is_empty;
        logic [4:0]  occupancy;
        logic [4:0]  removed_count;
    } t_out;

    typedef struct packed {
        logic [15:0] handle;
        logic [1:0]  kind;
        logic [15:0] agent;
        logic [31:0] stamp;
    } t_entry;

    typedef struct packed {
        logic enq;
        logic deq;
        logic mark;
        logic compact;
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/fifo_with_tagged_purge.sv]
// Ordered message queue with a selective purge by agent and time.
// Input channel i_in_valid / o_in_ready carries one request in i_in_data:
// enqueue, dequeue, purge or status query. Every request yields exactly one
// result on o_out_valid / i_out_ready in o_out_data.
// Entries live in a row of cells, one entry per cell, head in cell zero.
// Enqueue, dequeue and query results appear in the output register on the
// cycle after the request is taken, so while the receiver takes each result
// a steady stream of these runs at one request per cycle.
// A purge marks all matching cells in the cycle it is taken, then removes
// one marked cell per cycle by shifting the cells behind it one place
// toward the head, until no marked cell is left.
// While the output register holds a result that is not taken, no new
// request is taken, so a stalled receiver stalls the sender.
// Reset is synchronous and active low; it empties the queue and drops any
// pending result.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_tagged_purge #(
    parameter int QUEUE_DEPTH = fwtp_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire fwtp_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output fwtp_pkg::t_out     o_out_data
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_PURGE = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [FILL_W-1:0]   r_removed, n_removed;
    logic                r_out_valid, n_out_valid;
    fwtp_pkg::t_out      r_out, n_out;
    fwtp_pkg::t_cell_ctl w_ctl;
    fwtp_pkg::t_entry    w_new;
    logic                w_accept;
    logic                w_full;
    logic                w_any_dead;
    logic [FILL_W+4:0]   w_fill_ext;
    logic [FILL_W+4:0]   w_removed_ext;

    fwtp_pkg::t_entry    w_entry [QUEUE_DEPTH];
    logic                w_valid [QUEUE_DEPTH];
    logic                w_dead  [QUEUE_DEPTH];
    logic                w_seen  [QUEUE_DEPTH];

    assign w_new.handle = i_in_data.msg_handle;
    assign w_new.kind   = i_in_data.msg_kind;
    assign w_new.agent  = i_in_data.agent_id;
    assign w_new.stamp  = i_in_data.stamp;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic             w_prev_valid;
            logic             w_seen_in;
            fwtp_pkg::t_entry w_next_entry;
            logic             w_next_valid;
            logic             w_next_dead;

            if (g == 0) begin : g_head
                assign w_prev_valid = 1'b1;
                assign w_seen_in    = 1'b0;
            end else begin : g_body
                assign w_prev_valid = w_valid[g-1];
                assign w_seen_in    = w_seen[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_next_entry = '0;
                assign w_next_valid = 1'b0;
                assign w_next_dead  = 1'b0;
            end else begin : g_link
                assign w_next_entry = w_entry[g+1];
                assign w_next_valid = w_valid[g+1];
                assign w_next_dead  = w_dead[g+1];
            end

            fwtp_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_new        (w_new),
                .i_prev_valid (w_prev_valid),
                .i_next_entry (w_next_entry),
                .i_next_valid (w_next_valid),
                .i_next_dead  (w_next_dead),
                .i_dead_seen  (w_seen_in),
                .o_entry      (w_entry[g]),
                .o_valid      (w_valid[g]),
                .o_dead       (w_dead[g]),
                .o_dead_seen  (w_seen[g])
            );
        end
    endgenerate

    assign w_any_dead = w_seen[QUEUE_DEPTH-1];
    assign w_full     = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_removed   = r_removed;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_out       = r_out;
        w_ctl       = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out       = '0;
                    n_out.ok    = 1'b1;
                    n_out_valid = 1'b1;
                    case (i_in_data.opcode)
                        fwtp_pkg::OP_ENQUEUE: begin
                            if (!w_full) begin
                                w_ctl.enq = 1'b1;
                                n_fill    = r_fill + 1'b1;
                            end else begin
                                n_out.ok = 1'b0;
                            end
                        end
                        fwtp_pkg::OP_DEQUEUE: begin
                            if (r_fill != '0) begin
                                w_ctl.deq       = 1'b1;
                                n_fill          = r_fill - 1'b1;
                                n_out.out_handle = w_entry[0].handle;
                                n_out.out_kind   = w_entry[0].kind;
                                n_out.out_agent  = w_entry[0].agent;
                                n_out.out_stamp  = w_entry[0].stamp;
                            end else begin
                                n_out.ok = 1'b0;
                            end
                        end
                        fwtp_pkg::OP_PURGE: begin
                            w_ctl.mark  = 1'b1;
                            n_removed   = '0;
                            n_state     = S_PURGE;
                            n_out_valid = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PURGE: begin
                if (w_any_dead) begin
                    w_ctl.compact = 1'b1;
                    n_fill        = r_fill - 1'b1;
                    n_removed     = r_removed + 1'b1;
                end else begin
                    n_out       = '0;
                    n_out.ok    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        w_fill_ext    = {5'b0, n_fill};
        w_removed_ext = {5'b0, r_removed};
        if (n_out_valid && !r_out_valid || w_accept || (r_state == S_PURGE && !w_any_dead)) begin
            n_out.is_empty  = (n_fill == '0);
            n_out.occupancy = w_fill_ext[4:0];
            n_out.removed_count = (r_state == S_PURGE) ? w_removed_ext[4:0] : 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_removed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_removed   <= n_removed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[rtl/fwtp_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module fwtp_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fwtp_pkg::t_cell_ctl i_ctl,
    input  wire fwtp_pkg::t_entry   i_new,
    input  wire logic               i_prev_valid,
    input  wire fwtp_pkg::t_entry   i_next_entry,
    input  wire logic               i_next_valid,
    input  wire logic               i_next_dead,
    input  wire logic               i_dead_seen,
    output fwtp_pkg::t_entry        o_entry,
    output logic                    o_valid,
    output logic                    o_dead,
    output logic                    o_dead_seen
);

    fwtp_pkg::t_entry r_entry, n_entry;
    logic             r_valid, n_valid;
    logic             r_dead, n_dead;
    logic             w_hit;
    logic             w_shift;

    always_comb begin
        w_hit = 1'b0;
        if (r_entry.agent == i_new.agent) begin
            case (r_entry.kind)
                fwtp_pkg::KIND_READ:  w_hit = (r_entry.stamp >= i_new.stamp);
                fwtp_pkg::KIND_RANGE: w_hit = (r_entry.stamp >= i_new.stamp);
                fwtp_pkg::KIND_WRITE: w_hit = (r_entry.stamp > i_new.stamp);
                default:              w_hit = 1'b0;
            endcase
        end
    end

    assign o_dead_seen = i_dead_seen | r_dead;
    assign w_shift     = i_ctl.deq | (i_ctl.compact & o_dead_seen);

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        n_dead  = r_dead;
        if (w_shift) begin
            n_entry = i_next_entry;
            n_valid = i_next_valid;
            n_dead  = i_next_dead;
        end else if (i_ctl.enq && !r_valid && i_prev_valid) begin
            n_entry = i_new;
            n_valid = 1'b1;
        end else if (i_ctl.mark) begin
            n_dead = r_valid & w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dead  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_dead  <= n_dead;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;
    assign o_dead  = r_dead;

endmodule

`default_nettype wire

[rtl/fwtp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module fwtp_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_in_ready,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire fwtp_pkg::t_out o_out_data
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending right after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or vanished");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken while result stalled");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_empty |-> o_out_data.occupancy == 5'd0)
        else $error("empty flag disagrees with occupancy");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.ok |-> o_out_data.removed_count == 5'd0
            && o_out_data.out_handle == 16'd0 && o_out_data.out_stamp == 32'd0)
        else $error("failed request carries data");

endmodule

bind fifo_with_tagged_purge fwtp_checker u_fwtp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
